// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the falling sand grid block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: src/fsgu_pkg.sv
// ---------------------------------------------------------------------------
// fsgu_pkg
// Types and constants shared by the falling sand grid update modules.
// ---------------------------------------------------------------------------
package fsgu_pkg;

   // Default grid storage dimensions.
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 128;

   // Register reset values.
   localparam logic [7:0] RESET_GRID_COLUMNS = 8'd125;
   localparam logic [7:0] RESET_GRID_ROWS    = 8'd100;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_GRID_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_GRID_ROWS    = 2'd1;

   // Direction codes of a frame pass.
   localparam logic [2:0] SLIDE_LEFT  = 3'd1;
   localparam logic [2:0] SLIDE_RIGHT = 3'd2;

   // Action codes of a request beat.
   typedef enum logic [1:0] {
      ACT_SET   = 2'd0,
      ACT_FRAME = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // Per-column control handed to the cell step unit.
   typedef struct packed {
      logic slide_left;
      logic slide_right;
      logic left_ok;
      logic right_ok;
   } step_ctrl_type;

endpackage

// File: src/fsgu_ram.sv
// ---------------------------------------------------------------------------
// fsgu_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module fsgu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the entry being written
   // returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fsgu_cell_step.sv
// ---------------------------------------------------------------------------
// fsgu_cell_step
// Moves one grain of the current row into the row below: fall, or slide
// diagonally when the cell below is taken.
// ---------------------------------------------------------------------------
module fsgu_cell_step
   import fsgu_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic [MAX_COLUMNS-1:0]         cur_row,
   input  logic [MAX_COLUMNS-1:0]         below_row,
   input  logic [$clog2(MAX_COLUMNS)-1:0] col,
   input  step_ctrl_type                  ctrl,
   output logic [MAX_COLUMNS-1:0]         cur_next,
   output logic [MAX_COLUMNS-1:0]         below_next
);

   localparam int CW = $clog2(MAX_COLUMNS);

   logic [CW-1:0] col_left;
   logic [CW-1:0] col_right;

   assign col_left  = col - CW'(1);
   assign col_right = col + CW'(1);

   // Straight fall has priority; the diagonal target is only looked at when
   // the neighbor column exists inside the grid in use.
   always_comb begin
      cur_next   = cur_row;
      below_next = below_row;
      if (cur_row[col]) begin
         if (!below_row[col]) begin
            cur_next[col]   = 1'b0;
            below_next[col] = 1'b1;
         end else if (ctrl.slide_left) begin
            if (ctrl.left_ok && !below_row[col_left]) begin
               cur_next[col]        = 1'b0;
               below_next[col_left] = 1'b1;
            end
         end else if (ctrl.slide_right) begin
            if (ctrl.right_ok && !below_row[col_right]) begin
               cur_next[col]         = 1'b0;
               below_next[col_right] = 1'b1;
            end
         end
      end
   end

endmodule

// File: src/falling_sand_grid_update.sv
// Sequencing: a set or read beat goes through fetch and access to the result strobe;
// a clear or frame pass ends with the same fetch and access (a frame pass skips to them
// with no column or under two rows in use); the scan visits one cell per cycle in a row.
// Throughput: one request at a time; busy stays high until the result beat is shown.
// Reset: a clearing pass writes one row per cycle over all MAX_ROWS rows with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// falling_sand_grid_update
// Occupancy grid held as one RAM row per grid row, with a row-wise frame scan.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module falling_sand_grid_update
   import fsgu_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [6:0] req_cell_column,
   input  logic [6:0] req_cell_row,
   input  logic [2:0] req_slide_choice,
   output logic       rsp_strobe,
   output logic       rsp_cell_occupied,
   output logic       rsp_status,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   localparam int CW  = $clog2(MAX_COLUMNS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int UCW = $clog2(MAX_COLUMNS + 1);
   localparam int URW = $clog2(MAX_ROWS + 1);

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_FETCH   = 10'b00_0000_0100,
      ST_ACCESS  = 10'b00_0000_1000,
      ST_F_START = 10'b00_0001_0000,
      ST_F_BELOW = 10'b00_0010_0000,
      ST_F_CUR   = 10'b00_0100_0000,
      ST_F_SCAN  = 10'b00_1000_0000,
      ST_F_WRITE = 10'b01_0000_0000,
      ST_F_LAST  = 10'b10_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       grid_columns_ff, grid_columns_in;
   logic [7:0]       grid_rows_ff, grid_rows_in;
   logic [RW-1:0]    clr_row_ff, clr_row_in;
   logic             pending_ff, pending_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             rsp_occ_ff, rsp_occ_in;
   logic             rsp_status_ff, rsp_status_in;
   action_type       op_action_ff, op_action_in;
   logic [6:0]       op_col_ff, op_col_in;
   logic [6:0]       op_row_ff, op_row_in;
   logic [2:0]       op_choice_ff, op_choice_in;
   logic             inside_ff, inside_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [MAX_COLUMNS-1:0] cur_ff, cur_in;
   logic [MAX_COLUMNS-1:0] below_ff, below_in;

   logic [UCW-1:0]   used_cols;
   logic [URW-1:0]   used_rows;
   logic             req_inside;
   logic [CW-1:0]    op_col_idx;
   logic [MAX_COLUMNS-1:0] set_row;

   logic                   wr_en;
   logic [RW-1:0]          wr_addr;
   logic [MAX_COLUMNS-1:0] wr_data;
   logic [RW-1:0]          rd_addr;
   logic [MAX_COLUMNS-1:0] rd_data;

   step_ctrl_type          step_ctrl;
   logic [MAX_COLUMNS-1:0] step_cur;
   logic [MAX_COLUMNS-1:0] step_below;

   // Occupancy memory: one word per grid row.
   fsgu_ram #(
      .WIDTH(MAX_COLUMNS),
      .DEPTH(MAX_ROWS)
   ) u_grid_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Grain movement for the column under scan.
   fsgu_cell_step #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_cell_step (
      .cur_row   (cur_ff),
      .below_row (below_ff),
      .col       (col_ff),
      .ctrl      (step_ctrl),
      .cur_next  (step_cur),
      .below_next(step_below)
   );

   // Grid size in use, saturated at the storage size.
   assign used_cols = (32'(grid_columns_ff) > 32'(MAX_COLUMNS)) ? UCW'(MAX_COLUMNS)
                                                                 : UCW'(grid_columns_ff);
   assign used_rows = (32'(grid_rows_ff) > 32'(MAX_ROWS)) ? URW'(MAX_ROWS)
                                                           : URW'(grid_rows_ff);
   assign req_inside = (32'(req_cell_column) < 32'(used_cols)) &&
                       (32'(req_cell_row) < 32'(used_rows));

   assign step_ctrl.slide_left  = (op_choice_ff == SLIDE_LEFT);
   assign step_ctrl.slide_right = (op_choice_ff == SLIDE_RIGHT);
   assign step_ctrl.left_ok     = (col_ff != '0);
   assign step_ctrl.right_ok    = ((32'(col_ff) + 32'd1) < 32'(used_cols));

   // Addressed row with the addressed cell set, for the set action.
   assign op_col_idx = CW'(op_col_ff);
   always_comb begin
      set_row             = rd_data;
      set_row[op_col_idx] = 1'b1;
   end

   // Configuration writes.
   always_comb begin
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_COLUMNS: grid_columns_in = csr_write_data;
            CSR_GRID_ROWS:    grid_rows_in    = csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer: clearing pass, single-cell access and the row-wise frame scan.
   always_comb begin
      state_in      = state_ff;
      clr_row_in    = clr_row_ff;
      pending_in    = pending_ff;
      rsp_strobe_in = 1'b0;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      op_action_in  = op_action_ff;
      op_col_in     = op_col_ff;
      op_row_in     = op_row_ff;
      op_choice_in  = op_choice_ff;
      inside_in     = inside_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cur_in        = cur_ff;
      below_in      = below_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_row_ff;
            clr_row_in = clr_row_ff + RW'(1);
            if (clr_row_ff == RW'(MAX_ROWS - 1)) begin
               clr_row_in = '0;
               state_in   = pending_ff ? ST_FETCH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               pending_in   = 1'b1;
               op_action_in = action_type'(req_action);
               op_col_in    = req_cell_column;
               op_row_in    = req_cell_row;
               op_choice_in = req_slide_choice;
               inside_in    = req_inside;
               case (action_type'(req_action))
                  ACT_SET, ACT_READ: state_in = ST_FETCH;
                  ACT_FRAME:         state_in = ST_F_START;
                  ACT_CLEAR:         state_in = ST_CLEAR;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            rd_addr  = RW'(op_row_ff);
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            if (op_action_ff == ACT_SET && inside_ff) begin
               wr_en   = 1'b1;
               wr_addr = RW'(op_row_ff);
               wr_data = set_row;
            end
            rsp_strobe_in = 1'b1;
            rsp_occ_in    = inside_ff && ((op_action_ff == ACT_SET) || rd_data[op_col_idx]);
            rsp_status_in = !inside_ff;
            pending_in    = 1'b0;
            state_in      = ST_IDLE;
         end
         ST_F_START: begin
            if (used_cols == '0 || used_rows < URW'(2)) begin
               state_in = ST_FETCH;
            end else begin
               rd_addr  = RW'(used_rows - URW'(1));
               row_in   = RW'(used_rows - URW'(2));
               state_in = ST_F_BELOW;
            end
         end
         ST_F_BELOW: begin
            below_in = rd_data;
            rd_addr  = row_ff;
            state_in = ST_F_CUR;
         end
         ST_F_CUR: begin
            cur_in   = rd_data;
            col_in   = CW'(used_cols - UCW'(1));
            state_in = ST_F_SCAN;
         end
         ST_F_SCAN: begin
            cur_in   = step_cur;
            below_in = step_below;
            if (col_ff == '0) begin
               state_in = ST_F_WRITE;
            end else begin
               col_in = col_ff - CW'(1);
            end
         end
         ST_F_WRITE: begin
            // Row below is final; the current row becomes the next row below.
            wr_en    = 1'b1;
            wr_addr  = row_ff + RW'(1);
            wr_data  = below_ff;
            below_in = cur_ff;
            if (row_ff == '0) begin
               state_in = ST_F_LAST;
            end else begin
               row_in   = row_ff - RW'(1);
               rd_addr  = row_ff - RW'(1);
               state_in = ST_F_CUR;
            end
         end
         ST_F_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = below_ff;
            state_in = ST_FETCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_row_ff      <= '0;
         pending_ff      <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         grid_columns_ff <= RESET_GRID_COLUMNS;
         grid_rows_ff    <= RESET_GRID_ROWS;
      end else begin
         state_ff        <= state_in;
         clr_row_ff      <= clr_row_in;
         pending_ff      <= pending_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
      op_action_ff  <= op_action_in;
      op_col_ff     <= op_col_in;
      op_row_ff     <= op_row_in;
      op_choice_ff  <= op_choice_in;
      inside_ff     <= inside_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      cur_ff        <= cur_in;
      below_ff      <= below_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_cell_occupied = rsp_occ_ff;
   assign rsp_status        = rsp_status_ff;

   // Checks on the sequencer.
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted beat did not raise busy")
   `ASSERT_CLK(a_idle_no_write, clock, reset, !busy |-> !wr_en, "grid written while idle")
   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_strobe |-> !busy, "result beat shown while busy")
   `ASSERT_NEVER(a_rsp_outside, clock, reset, rsp_strobe && rsp_status && rsp_cell_occupied, "outside cell reported occupied")
   `ASSERT_NEVER(a_scan_no_write, clock, reset, (state_ff == ST_F_SCAN) && wr_en, "grid written during column scan")

endmodule
